// File: src/sht1x_measure_master_macros.svh
// ---------------------------------------------------------------------------
// SHT1x measurement master - assertion macros
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SHT1X_MEASURE_MASTER_MACROS_SVH
`define SHT1X_MEASURE_MASTER_MACROS_SVH

`ifndef SYNTH

`define SHT1X_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sht1x assertion failed");

`define SHT1X_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sht1x assertion failed");

`else

`define SHT1X_ASSERT_IMP(lbl, ante, cons)
`define SHT1X_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: src/sht1x_pkg.sv
// ---------------------------------------------------------------------------
// sht1x_pkg
// Shared types, codes and bus constants of the SHT1x measurement master.
// ---------------------------------------------------------------------------
`default_nettype none

package sht1x_pkg;

    // input commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_HALF_BIT = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd1;
    localparam logic [1:0] CFG_SETTLE   = 2'd2;

    localparam logic [7:0]  HALF_BIT_RST = 8'd1;
    localparam logic [15:0] TIMEOUT_RST  = 16'd65535;
    localparam logic [15:0] SETTLE_RST   = 16'd800;

    // sensor command bytes
    localparam logic [7:0] SENSOR_TEMP = 8'h03;
    localparam logic [7:0] SENSOR_HUMI = 8'h05;

    // transmission start pattern, bit i is step i
    localparam logic [7:0] START_SCK  = 8'b0011_0110;
    localparam logic [7:0] START_DATA = 8'b0110_0011;

    // classified tick word
    typedef struct packed {
        logic start;
        logic conn_reset;
        logic mode;
        logic din;
    } item_t;

    // command bit i of the sensor command, MSB first
    function automatic logic cmd_bit(input logic humi, input logic [2:0] idx);
        logic [7:0] code;
        code = humi ? SENSOR_HUMI : SENSOR_TEMP;
        return code[3'd7 - idx];
    endfunction

endpackage

`default_nettype wire

// File: src/sht1x_front.sv
// ---------------------------------------------------------------------------
// sht1x_front
// Accepts ticks and decodes the command into a queue word.
// ---------------------------------------------------------------------------
`default_nettype none

module sht1x_front (
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        cmd,
    input  wire logic              mode,
    input  wire logic              data_in,
    input  wire logic              full,
    output logic                   push,
    output sht1x_pkg::item_t       push_item
);

    assign in_stall = full;
    assign push     = in_valid && !full;

    // cmd 0 and the unused code 3 both decode to a plain tick
    always_comb
    begin
        push_item.start      = (cmd == sht1x_pkg::CMD_START);
        push_item.conn_reset = (cmd == sht1x_pkg::CMD_RESET);
        push_item.mode       = mode;
        push_item.din        = data_in;
    end

endmodule

`default_nettype wire

// File: src/sht1x_queue.sv
// ---------------------------------------------------------------------------
// sht1x_queue
// Small FIFO between the front decoder and the bus sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module sht1x_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire sht1x_pkg::item_t  push_item,
    output logic                   full,
    input  wire logic              pop,
    output logic                   q_valid,
    output sht1x_pkg::item_t       q_item
);

    `include "sht1x_measure_master_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sht1x_pkg::item_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_FULL);
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `SHT1X_ASSERT_IMP(a_no_push_full, push, count_reg != CNT_FULL)
    `SHT1X_ASSERT_IMP(a_no_pop_empty, pop, count_reg != '0)
    `SHT1X_ASSERT_NXT(a_cnt_grow, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

`default_nettype wire

// File: src/sht1x_seq.sv
// ---------------------------------------------------------------------------
// sht1x_seq
// Bus sequencer: advances the SHT1x pin sequence one tick per queue word
// and holds the result word until it is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module sht1x_seq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              q_valid,
    input  wire sht1x_pkg::item_t  q_item,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   sck_level,
    output logic                   data_release,
    output logic                   busy_res,
    output logic                   done_res,
    output logic [15:0]            measurement,
    output logic [7:0]             crc_byte,
    output logic [1:0]             error_count
);

    `include "sht1x_measure_master_macros.svh"

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_START  = 4'd1;
    localparam logic [3:0] PH_WR_LO  = 4'd2;
    localparam logic [3:0] PH_WR_HI  = 4'd3;
    localparam logic [3:0] PH_POLL   = 4'd4;
    localparam logic [3:0] PH_SETTLE = 4'd5;
    localparam logic [3:0] PH_RD_LO  = 4'd6;
    localparam logic [3:0] PH_RD_HI  = 4'd7;
    localparam logic [3:0] PH_FINAL  = 4'd8;
    localparam logic [3:0] PH_RST_LO = 4'd9;
    localparam logic [3:0] PH_RST_HI = 4'd10;

    // configuration
    logic [7:0]  half_bit_reg;
    logic [15:0] timeout_reg;
    logic [15:0] settle_reg;

    // sequencer state
    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  bit_idx_reg, bit_idx_next;
    logic [1:0]  byte_idx_reg, byte_idx_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] value_reg, value_next;
    logic [15:0] wait_cnt_reg, wait_cnt_next;
    logic [1:0]  err_reg, err_next;
    logic        mode_reg, mode_next;
    logic        sck_reg, sck_next;
    logic        data_reg, data_next;

    // result word
    logic        out_valid_reg, out_valid_next;
    logic        done_reg, done_next;
    logic [15:0] meas_reg;
    logic [7:0]  crc_reg;

    logic        fire;
    logic [7:0]  hold;
    logic [16:0] wait_plus;
    logic [15:0] wait_sat;
    logic [1:0]  err_inc;
    logic [3:0]  nb;

    assign fire = q_valid && (!out_valid_reg || !out_stall);
    assign pop  = fire;

    assign hold      = (half_bit_reg == 8'd0) ? 8'd1 : half_bit_reg;
    assign wait_plus = {1'b0, wait_cnt_reg} + 17'd1;
    assign wait_sat  = (wait_cnt_reg != 16'hFFFF) ? wait_plus[15:0] : wait_cnt_reg;
    assign err_inc   = (err_reg < 2'd2) ? err_reg + 2'd1 : err_reg;
    assign nb        = bit_idx_reg + 4'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        bit_idx_next  = bit_idx_reg;
        byte_idx_next = byte_idx_reg;
        shift_next    = shift_reg;
        value_next    = value_reg;
        wait_cnt_next = wait_cnt_reg;
        err_next      = err_reg;
        mode_next     = mode_reg;
        sck_next      = sck_reg;
        data_next     = data_reg;
        done_next     = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (q_item.start)
                begin
                    mode_next     = q_item.mode;
                    err_next      = 2'd0;
                    value_next    = 16'd0;
                    shift_next    = 8'd0;
                    byte_idx_next = 2'd0;
                    phase_next    = PH_START;
                    bit_idx_next  = 4'd0;
                    sck_next      = sht1x_pkg::START_SCK[0];
                    data_next     = sht1x_pkg::START_DATA[0];
                    wait_cnt_next = 16'd0;
                end
                else if (q_item.conn_reset)
                begin
                    phase_next    = PH_RST_LO;
                    bit_idx_next  = 4'd0;
                    sck_next      = 1'b0;
                    data_next     = 1'b1;
                    wait_cnt_next = 16'd0;
                end
            end
            PH_POLL:
            begin
                if (!q_item.din)
                begin
                    phase_next    = PH_SETTLE;
                    bit_idx_next  = 4'd0;
                    sck_next      = 1'b0;
                    data_next     = 1'b1;
                    wait_cnt_next = 16'd0;
                end
                else
                begin
                    wait_cnt_next = wait_sat;
                    if (wait_sat >= timeout_reg)
                    begin
                        err_next      = err_inc;
                        phase_next    = PH_SETTLE;
                        bit_idx_next  = 4'd0;
                        sck_next      = 1'b0;
                        data_next     = 1'b1;
                        wait_cnt_next = 16'd0;
                    end
                end
            end
            PH_SETTLE:
            begin
                if (wait_cnt_reg >= settle_reg)
                begin
                    byte_idx_next = 2'd0;
                    phase_next    = PH_RD_LO;
                    bit_idx_next  = 4'd0;
                    sck_next      = 1'b0;
                    data_next     = 1'b1;
                    wait_cnt_next = 16'd0;
                end
                else
                begin
                    wait_cnt_next = wait_plus[15:0];
                end
            end
            default:
            begin
                if (wait_plus < {9'd0, hold})
                begin
                    wait_cnt_next = wait_plus[15:0];
                end
                else
                begin
                    // end of a pin-level step
                    wait_cnt_next = 16'd0;
                    unique case (phase_reg)
                        PH_START:
                        begin
                            if (bit_idx_reg < 4'd7)
                            begin
                                bit_idx_next = nb;
                                sck_next     = sht1x_pkg::START_SCK[nb[2:0]];
                                data_next    = sht1x_pkg::START_DATA[nb[2:0]];
                            end
                            else
                            begin
                                phase_next   = PH_WR_LO;
                                bit_idx_next = 4'd0;
                                sck_next     = 1'b0;
                                data_next    = sht1x_pkg::cmd_bit(mode_reg, 3'd0);
                            end
                        end
                        PH_WR_LO:
                        begin
                            phase_next = PH_WR_HI;
                            sck_next   = 1'b1;
                        end
                        PH_WR_HI:
                        begin
                            if (bit_idx_reg < 4'd8)
                            begin
                                phase_next   = PH_WR_LO;
                                bit_idx_next = nb;
                                sck_next     = 1'b0;
                                data_next    = (nb < 4'd8)
                                             ? sht1x_pkg::cmd_bit(mode_reg, nb[2:0]) : 1'b1;
                            end
                            else
                            begin
                                // ack clock: sensor should hold DATA low
                                if (q_item.din)
                                begin
                                    err_next = err_inc;
                                end
                                phase_next   = PH_POLL;
                                bit_idx_next = 4'd0;
                                sck_next     = 1'b0;
                                data_next    = 1'b1;
                            end
                        end
                        PH_RD_LO:
                        begin
                            phase_next = PH_RD_HI;
                            sck_next   = 1'b1;
                        end
                        PH_RD_HI:
                        begin
                            if (bit_idx_reg < 4'd8)
                            begin
                                shift_next   = {shift_reg[6:0], q_item.din};
                                phase_next   = PH_RD_LO;
                                bit_idx_next = nb;
                                sck_next     = 1'b0;
                                // master acks the two data bytes, not the crc
                                data_next    = (nb < 4'd8) ? 1'b1
                                             : ((byte_idx_reg < 2'd2) ? 1'b0 : 1'b1);
                            end
                            else
                            begin
                                if (byte_idx_reg == 2'd0)
                                begin
                                    value_next = {shift_reg, 8'd0};
                                end
                                else if (byte_idx_reg == 2'd1)
                                begin
                                    value_next = value_reg | {8'd0, shift_reg};
                                end
                                bit_idx_next = 4'd0;
                                sck_next     = 1'b0;
                                data_next    = 1'b1;
                                if (byte_idx_reg < 2'd2)
                                begin
                                    byte_idx_next = byte_idx_reg + 2'd1;
                                    phase_next    = PH_RD_LO;
                                end
                                else
                                begin
                                    phase_next = PH_FINAL;
                                end
                            end
                        end
                        PH_FINAL:
                        begin
                            phase_next   = PH_IDLE;
                            bit_idx_next = 4'd0;
                            sck_next     = 1'b0;
                            data_next    = 1'b1;
                            done_next    = 1'b1;
                        end
                        PH_RST_LO:
                        begin
                            if (bit_idx_reg >= 4'd9)
                            begin
                                phase_next   = PH_IDLE;
                                bit_idx_next = 4'd0;
                                sck_next     = 1'b0;
                                data_next    = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_RST_HI;
                                sck_next   = 1'b1;
                                data_next  = 1'b1;
                            end
                        end
                        PH_RST_HI:
                        begin
                            phase_next   = PH_RST_LO;
                            bit_idx_next = nb;
                            sck_next     = 1'b0;
                            data_next    = 1'b1;
                        end
                        default:
                        begin
                            phase_next   = PH_IDLE;
                            bit_idx_next = 4'd0;
                            sck_next     = 1'b0;
                            data_next    = 1'b1;
                        end
                    endcase
                end
            end
        endcase
    end

    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_bit_reg <= sht1x_pkg::HALF_BIT_RST;
            timeout_reg  <= sht1x_pkg::TIMEOUT_RST;
            settle_reg   <= sht1x_pkg::SETTLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sht1x_pkg::CFG_HALF_BIT: half_bit_reg <= cfg_data[7:0];
                sht1x_pkg::CFG_TIMEOUT:  timeout_reg  <= cfg_data;
                sht1x_pkg::CFG_SETTLE:   settle_reg   <= cfg_data;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_idx_reg   <= 4'd0;
            byte_idx_reg  <= 2'd0;
            shift_reg     <= 8'd0;
            value_reg     <= 16'd0;
            wait_cnt_reg  <= 16'd0;
            err_reg       <= 2'd0;
            mode_reg      <= 1'b0;
            sck_reg       <= 1'b0;
            data_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                phase_reg    <= phase_next;
                bit_idx_reg  <= bit_idx_next;
                byte_idx_reg <= byte_idx_next;
                shift_reg    <= shift_next;
                value_reg    <= value_next;
                wait_cnt_reg <= wait_cnt_next;
                err_reg      <= err_next;
                mode_reg     <= mode_next;
                sck_reg      <= sck_next;
                data_reg     <= data_next;
                done_reg     <= done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            meas_reg <= done_next ? value_next : 16'd0;
            crc_reg  <= done_next ? shift_next : 8'd0;
        end
    end

    // pin and status levels come straight from the state, which only
    // moves together with the result word
    assign out_valid    = out_valid_reg;
    assign sck_level    = sck_reg;
    assign data_release = data_reg;
    assign busy_res     = (phase_reg != PH_IDLE);
    assign done_res     = done_reg;
    assign measurement  = meas_reg;
    assign crc_byte     = crc_reg;
    assign error_count  = err_reg;

    `SHT1X_ASSERT_IMP(a_err_sat, 1'b1, err_reg != 2'd3)
    `SHT1X_ASSERT_IMP(a_done_idle, out_valid_reg && done_reg, phase_reg == PH_IDLE)
    `SHT1X_ASSERT_IMP(a_phase_known, 1'b1, phase_reg <= PH_RST_HI)
    `SHT1X_ASSERT_NXT(a_hold_stalled, out_valid_reg && out_stall, phase_reg == $past(phase_reg))

endmodule

`default_nettype wire

// File: src/sht1x_measure_master.sv
// A tick's result word passes the tick queue, then the sequencer's output register.
// Throughput: one tick per cycle; the queue and the output register let the input
// keep flowing while a result waits, the input stalls only when the queue is full.
// Bus step time is half_bit_reg ticks (0 acts as 1), so bus timing scales with the tick rate.
// Reset: sequencer idle, SCK low, DATA released, config registers at their defaults.
// ---------------------------------------------------------------------------
// sht1x_measure_master
// Tick-driven SHT1x two-wire master: front decoder, tick queue, bus sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module sht1x_measure_master #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic        mode,
    input  wire logic        data_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             sck_level,
    output logic             data_release,
    output logic             busy_res,
    output logic             done_res,
    output logic [15:0]      measurement,
    output logic [7:0]       crc_byte,
    output logic [1:0]       error_count
);

    logic             full;
    logic             push;
    logic             pop;
    logic             q_valid;
    sht1x_pkg::item_t push_item;
    sht1x_pkg::item_t q_item;

    sht1x_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .mode      (mode),
        .data_in   (data_in),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    sht1x_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    sht1x_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sck_level    (sck_level),
        .data_release (data_release),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .measurement  (measurement),
        .crc_byte     (crc_byte),
        .error_count  (error_count)
    );

endmodule

`default_nettype wire
